// ===== rtl/imhq_pkg.sv =====
// types, constants and the key compare for the indexed max-heap queue
// used by indexed_max_heap_queue; no dependencies
package imhq_pkg;

  localparam int HEAP_DEPTH   = 256;
  localparam int HANDLE_COUNT = 256;
  localparam int KEY_BITS     = 32;
  localparam int SLOT_W       = 8;
  localparam int CNT_W        = 9;
  localparam int HND_W        = 9;

  localparam logic [CNT_W-1:0] HEAP_FULL = 9'd256;
  localparam logic [HND_W-1:0] NO_HANDLE = 9'd256;
  localparam logic [CNT_W-1:0] NO_SLOT   = 9'd256;

  typedef enum logic [2:0] {
    FN_INSERT  = 3'd0,
    FN_REMOVE  = 3'd1,
    FN_REKEY   = 3'd2,
    FN_POP     = 3'd3,
    FN_CONTAIN = 3'd4,
    FN_CLEAR   = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NULLKEY = 3'd1,
    ST_FULL    = 3'd2,
    ST_BADPOS  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_RM_A, S_RM_B, S_RM_C,
    S_RK_A, S_RK_B,
    S_SD_RL, S_SD_RR, S_SD_CR, S_SD_DEC, S_SD_W2,
    S_RE_A, S_RE_B,
    S_SU_RP, S_SU_CP, S_SU_W2,
    S_CS_A, S_CS_B,
    S_FIN, S_RESP
  } state_t;

  typedef struct packed {
    logic [HND_W-1:0]    hnd;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  // strict greater-than, signed mode flips the sign bits
  function automatic logic key_gt(input logic [KEY_BITS-1:0] a,
                                  input logic [KEY_BITS-1:0] b,
                                  input logic sgn);
    logic [KEY_BITS-1:0] ax;
    logic [KEY_BITS-1:0] bx;
    ax = a ^ {sgn, {(KEY_BITS-1){1'b0}}};
    bx = b ^ {sgn, {(KEY_BITS-1){1'b0}}};
    return ax > bx;
  endfunction

endpackage

// ===== rtl/indexed_max_heap_queue.sv =====
// indexed binary max-heap priority queue with handle-to-slot tracking
// depends on imhq_pkg
//
// channel  dir  handshake             payload
// in       in   in_tvalid/in_tready   tuser: func; tdata: key, handle, has_handle, position
// out      out  out_tvalid/out_tready tuser: status; tdata: key_out, handle_out, found,
//                                     entry_count, handle_position
// cfg      in   cfg_we                cfg_wdata: signed_keys
//
// one item at a time; a sequencer shares one heap ram port and one key comparator.
// insert sifts the new entry up; remove and pop move the last entry into the freed slot,
// then sift it down and up (removing the last slot needs no sift); rekey sifts down and up
// without the move; contain scans the live entries in slot order.
// reset clears the count and every handle valid bit at once, no clearing pass.
// input is taken only when the sequencer is idle; a result waiting in the output
// register does not block the next transfer, only the next result.
module indexed_max_heap_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // func
  input  logic [55:0] in_tdata,   // key[31:0], handle[39:32], has_handle[40], position[48:41]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // status
  output logic [63:0] out_tdata,  // key_out[31:0], handle_out[40:32], found[41],
                                  // entry_count[50:42], handle_position[59:51]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_wdata   // signed_keys
);
  import imhq_pkg::*;

  state_t state_r, state_nxt;

  // memories
  entry_t             hm_mem [HEAP_DEPTH];
  logic [SLOT_W-1:0]  hs_mem [HANDLE_COUNT];
  entry_t             hm_rdata_r;
  logic [SLOT_W-1:0]  hs_rdata_r;
  logic               hv_q_r;
  logic [HANDLE_COUNT-1:0] hv_r;

  logic               hm_we;
  logic [SLOT_W-1:0]  hm_waddr, hm_raddr;
  entry_t             hm_wdata;
  logic               hs_put;
  logic [HND_W-1:0]   hs_put_h;
  logic [SLOT_W-1:0]  hs_put_slot;
  logic               hv_clr, hv_clr_all;
  logic [SLOT_W-1:0]  hv_clr_idx;

  // latched item
  logic [2:0]          func_r;
  logic [KEY_BITS-1:0] key_r;
  logic [7:0]          handle_r;
  logic                has_handle_r;
  logic [SLOT_W-1:0]   pos_r, pos_nxt;

  logic                signed_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SLOT_W-1:0]   i_r, i_nxt, m_r, m_nxt;
  entry_t              cur_r, cur_nxt, best_r, best_nxt;

  logic [2:0]          st_r, st_nxt;
  logic [KEY_BITS-1:0] kout_r, kout_nxt;
  logic [HND_W-1:0]    hout_r, hout_nxt;
  logic                found_r, found_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_st_r, out_st_nxt;
  logic [63:0]         out_data_r, out_data_nxt;

  logic [CNT_W-1:0]    lchild;
  logic [CNT_W:0]      rchild;
  logic [SLOT_W-1:0]   parent;
  logic [CNT_W-1:0]    last_idx;
  logic [KEY_BITS-1:0] cmp_a, cmp_b;
  logic                cmp_gt;
  logic [HND_W-1:0]    hpos;
  logic                accept;

  assign lchild   = {i_r, 1'b1};
  assign rchild   = {1'b0, i_r, 1'b0} + 10'd2;
  assign parent   = (i_r - 8'd1) >> 1;
  assign last_idx = count_r - 9'd1;
  assign accept   = in_tvalid && in_tready;
  assign hpos     = hv_q_r ? {1'b0, hs_rdata_r} : NO_SLOT;

  // shared comparator
  always_comb begin
    cmp_a = hm_rdata_r.key;
    cmp_b = cur_r.key;
    if (state_r == S_SD_CR) begin
      cmp_b = best_r.key;
    end else if (state_r == S_SU_CP) begin
      cmp_a = cur_r.key;
      cmp_b = hm_rdata_r.key;
    end
  end
  assign cmp_gt = key_gt(cmp_a, cmp_b, signed_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    m_nxt         = m_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    st_nxt        = st_r;
    kout_nxt      = kout_r;
    hout_nxt      = hout_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_data_nxt  = out_data_r;
    hm_we         = 1'b0;
    hm_waddr      = i_r;
    hm_wdata      = cur_r;
    hm_raddr      = pos_r;
    hs_put        = 1'b0;
    hs_put_h      = cur_r.hnd;
    hs_put_slot   = i_r;
    hv_clr        = 1'b0;
    hv_clr_idx    = 8'd0;
    hv_clr_all    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_nxt   = in_tdata[48:41];
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        st_nxt    = ST_OK;
        kout_nxt  = '0;
        hout_nxt  = NO_HANDLE;
        found_nxt = 1'b0;
        state_nxt = S_FIN;
        priority case (func_r)
          FN_INSERT: begin
            if (key_r == '0) begin
              st_nxt = ST_NULLKEY;
            end else if (count_r == HEAP_FULL) begin
              st_nxt = ST_FULL;
            end else begin
              cur_nxt.key = key_r;
              cur_nxt.hnd = has_handle_r ? {1'b0, handle_r} : NO_HANDLE;
              hm_we       = 1'b1;
              hm_waddr    = count_r[SLOT_W-1:0];
              hm_wdata    = cur_nxt;
              hs_put      = 1'b1;
              hs_put_h    = cur_nxt.hnd;
              hs_put_slot = count_r[SLOT_W-1:0];
              i_nxt       = count_r[SLOT_W-1:0];
              count_nxt   = count_r + 9'd1;
              state_nxt   = S_SU_RP;
            end
          end
          FN_REMOVE: begin
            if ({1'b0, pos_r} >= count_r) st_nxt = ST_BADPOS;
            else                          state_nxt = S_RM_A;
          end
          FN_REKEY: begin
            if ({1'b0, pos_r} >= count_r) st_nxt = ST_BADPOS;
            else if (key_r == '0)         st_nxt = ST_NULLKEY;
            else                          state_nxt = S_RK_A;
          end
          FN_POP: begin
            if (count_r == '0) begin
              st_nxt = ST_EMPTY;
            end else begin
              pos_nxt   = '0;
              state_nxt = S_RM_A;
            end
          end
          FN_CONTAIN: begin
            i_nxt     = '0;
            state_nxt = S_CS_A;
          end
          FN_CLEAR: begin
            hv_clr_all = 1'b1;
            count_nxt  = '0;
          end
          default: ;
        endcase
      end
      S_RM_A: begin
        hm_raddr  = pos_r;
        state_nxt = S_RM_B;
      end
      S_RM_B: begin
        if (func_r == FN_POP) begin
          kout_nxt = hm_rdata_r.key;
          hout_nxt = hm_rdata_r.hnd;
        end
        if (!hm_rdata_r.hnd[HND_W-1]) begin
          hv_clr     = 1'b1;
          hv_clr_idx = hm_rdata_r.hnd[SLOT_W-1:0];
        end
        count_nxt = last_idx;
        hm_raddr  = last_idx[SLOT_W-1:0];
        if ({1'b0, pos_r} == last_idx) state_nxt = S_FIN;
        else                           state_nxt = S_RM_C;
      end
      S_RM_C: begin
        hm_we       = 1'b1;
        hm_waddr    = pos_r;
        hm_wdata    = hm_rdata_r;
        hs_put      = 1'b1;
        hs_put_h    = hm_rdata_r.hnd;
        hs_put_slot = pos_r;
        cur_nxt     = hm_rdata_r;
        i_nxt       = pos_r;
        state_nxt   = S_SD_RL;
      end
      S_RK_A: begin
        hm_raddr  = pos_r;
        state_nxt = S_RK_B;
      end
      S_RK_B: begin
        cur_nxt.hnd = hm_rdata_r.hnd;
        cur_nxt.key = key_r;
        hm_we       = 1'b1;
        hm_waddr    = pos_r;
        hm_wdata    = cur_nxt;
        i_nxt       = pos_r;
        state_nxt   = S_SD_RL;
      end
      S_SD_RL: begin
        hm_raddr = lchild[SLOT_W-1:0];
        if (lchild >= count_r) state_nxt = S_RE_A;
        else                   state_nxt = S_SD_RR;
      end
      S_SD_RR: begin
        hm_raddr = rchild[SLOT_W-1:0];
        if (cmp_gt) begin
          best_nxt = hm_rdata_r;
          m_nxt    = lchild[SLOT_W-1:0];
        end else begin
          best_nxt = cur_r;
          m_nxt    = i_r;
        end
        if (rchild < {1'b0, count_r}) state_nxt = S_SD_CR;
        else                          state_nxt = S_SD_DEC;
      end
      S_SD_CR: begin
        if (cmp_gt) begin
          best_nxt = hm_rdata_r;
          m_nxt    = rchild[SLOT_W-1:0];
        end
        state_nxt = S_SD_DEC;
      end
      S_SD_DEC: begin
        if (m_r == i_r) begin
          state_nxt = S_RE_A;
        end else begin
          // sifted entry goes down first, the child follows into its old slot
          hm_we       = 1'b1;
          hm_waddr    = m_r;
          hm_wdata    = cur_r;
          hs_put      = 1'b1;
          hs_put_h    = cur_r.hnd;
          hs_put_slot = m_r;
          state_nxt   = S_SD_W2;
        end
      end
      S_SD_W2: begin
        hm_we       = 1'b1;
        hm_waddr    = i_r;
        hm_wdata    = best_r;
        hs_put      = 1'b1;
        hs_put_h    = best_r.hnd;
        hs_put_slot = i_r;
        i_nxt       = m_r;
        state_nxt   = S_SD_RL;
      end
      S_RE_A: begin
        hm_raddr  = pos_r;
        state_nxt = S_RE_B;
      end
      S_RE_B: begin
        cur_nxt   = hm_rdata_r;
        i_nxt     = pos_r;
        state_nxt = S_SU_RP;
      end
      S_SU_RP: begin
        hm_raddr = parent;
        if (i_r == '0) state_nxt = S_FIN;
        else           state_nxt = S_SU_CP;
      end
      S_SU_CP: begin
        if (!cmp_gt) begin
          state_nxt = S_FIN;
        end else begin
          hm_we       = 1'b1;
          hm_waddr    = parent;
          hm_wdata    = cur_r;
          hs_put      = 1'b1;
          hs_put_h    = cur_r.hnd;
          hs_put_slot = parent;
          best_nxt    = hm_rdata_r;
          state_nxt   = S_SU_W2;
        end
      end
      S_SU_W2: begin
        hm_we       = 1'b1;
        hm_waddr    = i_r;
        hm_wdata    = best_r;
        hs_put      = 1'b1;
        hs_put_h    = best_r.hnd;
        hs_put_slot = i_r;
        i_nxt       = parent;
        state_nxt   = S_SU_RP;
      end
      S_CS_A: begin
        hm_raddr = i_r;
        if ({1'b0, i_r} >= count_r) state_nxt = S_FIN;
        else                        state_nxt = S_CS_B;
      end
      S_CS_B: begin
        if (hm_rdata_r.key == key_r) begin
          found_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          i_nxt = i_r + 8'd1;
          // wrap past the last slot means the whole store was scanned
          if (i_r == 8'hff) state_nxt = S_FIN;
          else              state_nxt = S_CS_A;
        end
      end
      S_FIN: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = st_r;
          out_data_nxt  = {4'd0, hpos, count_r, found_r, hout_r, kout_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      signed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      hv_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) signed_r <= cfg_wdata[0];
      if (hv_clr_all) begin
        hv_r <= '0;
      end else begin
        if (hv_clr) hv_r[hv_clr_idx] <= 1'b0;
        if (hs_put && !hs_put_h[HND_W-1]) hv_r[hs_put_h[SLOT_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r       <= in_tuser;
      key_r        <= in_tdata[31:0];
      handle_r     <= in_tdata[39:32];
      has_handle_r <= in_tdata[40];
    end
    pos_r      <= pos_nxt;
    i_r        <= i_nxt;
    m_r        <= m_nxt;
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    st_r       <= st_nxt;
    kout_r     <= kout_nxt;
    hout_r     <= hout_nxt;
    found_r    <= found_nxt;
    out_st_r   <= out_st_nxt;
    out_data_r <= out_data_nxt;
  end

  // heap ram and handle-to-slot ram
  always_ff @(posedge clk) begin
    if (hm_we) hm_mem[hm_waddr] <= hm_wdata;
    hm_rdata_r <= hm_mem[hm_raddr];
  end

  always_ff @(posedge clk) begin
    if (hs_put && !hs_put_h[HND_W-1]) hs_mem[hs_put_h[SLOT_W-1:0]] <= hs_put_slot;
    hs_rdata_r <= hs_mem[handle_r];
    hv_q_r     <= hv_r[handle_r];
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= HEAP_FULL)
    else $error("entry count above heap depth");

  a_sift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SD_RL || state_r == S_SU_RP) |-> ({1'b0, i_r} < count_r))
    else $error("sift index outside the live heap");

  a_clear_drops_handles: assert property (@(posedge clk) disable iff (!rst_n)
    hv_clr_all |=> (hv_r == '0) && (count_r == '0))
    else $error("clear left a tracked handle");

  a_resp_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && (!out_valid_r || out_tready)) |=> out_valid_r && state_r == S_IDLE)
    else $error("result not moved to output register");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for indexed_max_heap_queue: drives heap operations, predicts results
// with a behavioral heap model; depends on imhq_pkg and the dut
`timescale 1ns / 1ps

module tb_top;
  import imhq_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [2:0]  in_tuser;   // func
  logic [55:0] in_tdata;   // key[31:0], handle[39:32], has_handle[40], position[48:41]
  logic        out_tvalid;
  logic        out_tready;
  logic [2:0]  out_tuser;  // status
  logic [63:0] out_tdata;  // key_out[31:0], handle_out[40:32], found[41],
                           // entry_count[50:42], handle_position[59:51]
  logic        cfg_we;
  logic [0:0]  cfg_wdata;

  indexed_max_heap_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] data;
  } heap_resp_t;

  // behavioral heap
  logic [31:0] mkey [HEAP_DEPTH];
  logic [8:0]  mhnd [HEAP_DEPTH];
  logic [8:0]  mpos [HANDLE_COUNT];
  int          mcount;
  logic        msigned;

  heap_resp_t  resp_q[$];
  int          errors;
  int          mismatches;
  int          cycles;
  int          send_idle;
  int          recv_idle;
  int          hold_req;
  int          hold_ack;
  int          hold_left;

  function automatic bit gt(logic [31:0] a, logic [31:0] b);
    if (msigned) return $signed(a) > $signed(b);
    return a > b;
  endfunction

  function automatic void place(int d, logic [31:0] k, logic [8:0] h);
    mkey[d] = k;
    mhnd[d] = h;
    if (h < HANDLE_COUNT) mpos[h[7:0]] = d[8:0];
  endfunction

  function automatic void swap(int a, int b);
    logic [31:0] ka;
    logic [8:0]  ha;
    ka = mkey[a];
    ha = mhnd[a];
    place(a, mkey[b], mhnd[b]);
    place(b, ka, ha);
  endfunction

  function automatic void sink(int i);
    int l, r, m;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      m = i;
      if (l < mcount && gt(mkey[l], mkey[m])) m = l;
      if (r < mcount && gt(mkey[r], mkey[m])) m = r;
      if (m == i) return;
      swap(m, i);
      i = m;
    end
  endfunction

  function automatic void rise(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) >> 1;
      if (!gt(mkey[i], mkey[p])) return;
      swap(p, i);
      i = p;
    end
  endfunction

  function automatic void take_out(int p);
    if (mhnd[p] < HANDLE_COUNT) mpos[mhnd[p][7:0]] = NO_SLOT;
    mcount--;
    if (p != mcount) begin
      place(p, mkey[mcount], mhnd[mcount]);
      sink(p);
      rise(p);
    end
  endfunction

  function automatic heap_resp_t heap_apply(logic [2:0] fn, logic [31:0] k, logic [7:0] h,
                                            logic hh, logic [7:0] p);
    heap_resp_t  rs;
    logic [2:0]  st;
    logic [31:0] ko;
    logic [8:0]  ho;
    logic        fd;
    st = ST_OK; ko = '0; ho = NO_HANDLE; fd = 1'b0;
    case (fn)
      FN_INSERT: begin
        if (k == 0) st = ST_NULLKEY;
        else if (mcount >= HEAP_DEPTH) st = ST_FULL;
        else begin
          place(mcount, k, hh ? {1'b0, h} : NO_HANDLE);
          mcount++;
          rise(mcount - 1);
        end
      end
      FN_REMOVE: begin
        if (p >= mcount) st = ST_BADPOS;
        else take_out(p);
      end
      FN_REKEY: begin
        if (p >= mcount) st = ST_BADPOS;
        else if (k == 0) st = ST_NULLKEY;
        else begin
          mkey[p] = k;
          sink(p);
          rise(p);
        end
      end
      FN_POP: begin
        if (mcount == 0) st = ST_EMPTY;
        else begin
          ko = mkey[0];
          ho = mhnd[0];
          take_out(0);
        end
      end
      FN_CONTAIN: begin
        for (int i = 0; i < mcount; i++) if (mkey[i] == k) fd = 1'b1;
      end
      FN_CLEAR: begin
        for (int i = 0; i < mcount; i++)
          if (mhnd[i] < HANDLE_COUNT) mpos[mhnd[i][7:0]] = NO_SLOT;
        mcount = 0;
      end
      default: ;
    endcase
    rs.status = st;
    rs.data = {4'b0, mpos[h], mcount[8:0], fd, ho, ko};
    return rs;
  endfunction

  // valid stays up between items sent back to back and drops only while idling
  task automatic send_op(logic [2:0] fn, logic [31:0] k, logic [7:0] h, logic hh,
                         logic [7:0] p);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    resp_q.push_back(heap_apply(fn, k, h, hh, p));
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {7'b0, p, hh, h, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (resp_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_mode(logic s);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we    <= 1'b0;
    msigned = s;
  endtask

  // small key pool so contain hits and ties happen
  function automatic logic [31:0] pick_key();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_op();
    int r;
    logic [7:0] p;
    r = $urandom_range(99);
    p = (mcount > 0 && $urandom_range(9) > 0) ? 8'($urandom_range(mcount - 1)) : 8'($urandom);
    if (r < 45)      send_op(FN_INSERT, pick_key(), 8'($urandom), 1'($urandom), p);
    else if (r < 58) send_op(FN_REMOVE, pick_key(), 8'($urandom), 1'($urandom), p);
    else if (r < 70) send_op(FN_REKEY, pick_key(), 8'($urandom), 1'($urandom), p);
    else if (r < 85) send_op(FN_POP, pick_key(), 8'($urandom), 1'($urandom), p);
    else if (r < 96) send_op(FN_CONTAIN, pick_key(), 8'($urandom), 1'($urandom), p);
    else if (r < 98) send_op(FN_CLEAR, $urandom, 8'($urandom), 1'($urandom), p);
    else             send_op(3'($urandom_range(7, 6)), $urandom, 8'($urandom), 1'($urandom), p);
  endtask

  task automatic test_directed();
    send_op(FN_POP, 32'd0, 8'd3, 1'b0, 8'd0);
    send_op(FN_INSERT, 32'd0, 8'd1, 1'b1, 8'd0);
    send_op(FN_REMOVE, 32'd5, 8'd1, 1'b0, 8'd0);
    send_op(FN_INSERT, 32'hFFFF_FFFF, 8'd0, 1'b1, 8'd0);
    send_op(FN_INSERT, 32'h8000_0000, 8'd255, 1'b1, 8'd0);
    send_op(FN_INSERT, 32'h1, 8'd7, 1'b1, 8'd0);
    send_op(FN_INSERT, 32'h7FFF_FFFF, 8'd7, 1'b1, 8'd0);
    send_op(FN_INSERT, 32'h55, 8'd9, 1'b0, 8'd0);
    send_op(FN_CONTAIN, 32'h55, 8'd7, 1'b0, 8'd0);
    send_op(FN_CONTAIN, 32'h56, 8'd255, 1'b0, 8'd0);
    send_op(FN_REKEY, 32'd0, 8'd0, 1'b0, 8'd1);
    send_op(FN_REKEY, 32'h2, 8'd0, 1'b0, 8'd0);
    send_op(FN_REKEY, 32'h9, 8'd0, 1'b0, 8'd200);
    send_op(FN_REMOVE, 32'd0, 8'd255, 1'b0, 8'd4);
    send_op(FN_REMOVE, 32'd0, 8'd255, 1'b0, 8'd255);
    send_op(3'd6, 32'hAAAA_AAAA, 8'd7, 1'b1, 8'hAA);
    send_op(3'd7, 32'h5555_5555, 8'd7, 1'b1, 8'h55);
    send_op(FN_POP, 32'd0, 8'd7, 1'b0, 8'd0);
    send_op(FN_POP, 32'd0, 8'd7, 1'b0, 8'd0);
    send_op(FN_CLEAR, 32'd0, 8'd7, 1'b0, 8'd0);
    send_op(FN_CONTAIN, 32'd0, 8'd7, 1'b0, 8'd0);
  endtask

  task automatic test_signed();
    set_mode(1'b1);
    send_op(FN_INSERT, 32'h8000_0000, 8'd1, 1'b1, 8'd0);
    send_op(FN_INSERT, 32'hFFFF_FFFF, 8'd2, 1'b1, 8'd0);
    send_op(FN_INSERT, 32'h7FFF_FFFF, 8'd3, 1'b1, 8'd0);
    send_op(FN_INSERT, 32'h1, 8'd4, 1'b1, 8'd0);
    repeat (4) send_op(FN_POP, 32'd0, 8'd1, 1'b0, 8'd0);
  endtask

  task automatic test_random(int n);
    repeat (n) random_op();
  endtask

  // fill to full, starting under a receiver hold-off, reject one more insert, then remove and pop
  task automatic test_full();
    drain();
    hold_req++;
    send_op(FN_CLEAR, 32'd0, 8'd0, 1'b0, 8'd0);
    for (int i = 0; i < HEAP_DEPTH; i++)
      send_op(FN_INSERT, ($urandom_range(1000) + 1), 8'(i), 1'b1, 8'd0);
    send_op(FN_INSERT, 32'h1234, 8'd5, 1'b1, 8'd0);
    send_op(FN_REMOVE, 32'd0, 8'd5, 1'b0, 8'd255);
    drain();
    repeat (16) send_op(FN_POP, 32'd0, 8'($urandom), 1'b0, 8'd0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tuser = '0; in_tdata = '0;
    cfg_we = 1'b0; cfg_wdata = '0;
    mcount = 0; msigned = 1'b0; errors = 0; mismatches = 0;
    send_idle = 10; recv_idle = 58; hold_req = 0;
    for (int i = 0; i < HANDLE_COUNT; i++) mpos[i] = NO_SLOT;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(55);
    test_signed();
    send_idle = 58; recv_idle = 10;
    test_random(55);
    set_mode(1'b0);
    send_idle = 0; recv_idle = 0;
    test_full();
    test_random(40);
    drain();
    if (errors == 0) $display("[indexed_max_heap_queue] OK");
    else $display("[indexed_max_heap_queue] ERROR");
    $finish;
  end

  // receiver: a new hold request stalls the output for a long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_ack   <= hold_req;
      hold_left  <= 0;
    end else if (hold_req != hold_ack) begin
      out_tready <= 1'b0;
      hold_ack   <= hold_req;
      hold_left  <= 600;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    heap_resp_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (resp_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result transfer %h %h", out_tuser, out_tdata);
      end else begin
        exp_r = resp_q.pop_front();
        if (exp_r.status !== out_tuser || exp_r.data !== out_tdata) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: exp status %0d data %h, got status %0d data %h",
                     exp_r.status, exp_r.data, out_tuser, out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[indexed_max_heap_queue] ERROR");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
